// ===== design/sgcd_pkg.sv =====
// shared types for the signed gcd unit: beat payloads, controller states,
// controller-to-datapath command and status groups
// no dependencies
package sgcd_pkg;

   // default working width of the operand magnitudes
   localparam int OperandWidthDefault = 32;

   // fixed width of the payload fields
   localparam int FieldWidth = 32;

   // input beat
   typedef struct packed {
      logic signed [FieldWidth-1:0] value_a;
      logic signed [FieldWidth-1:0] value_b;
   } req_type;

   // result beat
   typedef struct packed {
      logic [FieldWidth-1:0] divisor;
      logic                  zero_operand;
   } rsp_type;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV_INIT,
      ST_DIVIDE,
      ST_UPDATE,
      ST_FINISH
   } sgcd_state_type;

   // commands to the datapath
   typedef struct packed {
      logic load;      // take the operand magnitudes
      logic div_init;  // start a remainder pass on larger / smaller
      logic div_step;  // one restoring remainder bit
      logic update;    // larger <= smaller, smaller <= remainder
   } sgcd_cmd_type;

   // status from the datapath
   typedef struct packed {
      logic zero_operand;  // an operand was zero at load
      logic smaller_zero;  // smaller working value is zero
      logic count_last;    // last remainder bit in progress
   } sgcd_status_type;

endpackage

// ===== design/sgcd_dpath.sv =====
// datapath of the signed gcd unit: working magnitudes and a bit-serial
// restoring remainder unit
// depends on sgcd_pkg
module sgcd_dpath #(
   parameter int OPERAND_WIDTH = sgcd_pkg::OperandWidthDefault
) (
   input  logic                         clock,
   input  logic [OPERAND_WIDTH-1:0]     op_a,
   input  logic [OPERAND_WIDTH-1:0]     op_b,
   input  sgcd_pkg::sgcd_cmd_type       cmd,
   output sgcd_pkg::sgcd_status_type    status,
   output logic [OPERAND_WIDTH-1:0]     result
);
   import sgcd_pkg::*;

   localparam int W    = OPERAND_WIDTH;
   localparam int CntW = $clog2(W);

   logic [W-1:0]    larger_ff, larger_in;
   logic [W-1:0]    smaller_ff, smaller_in;
   logic [W-1:0]    rem_ff, rem_in;
   logic [W-1:0]    shift_ff, shift_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            zero_ff, zero_in;

   logic [W-1:0]    mag_a;
   logic [W-1:0]    mag_b;
   logic [W:0]      rem_sh;
   logic [W:0]      rem_diff;

   // two's complement magnitudes; the most negative value maps to 2^(W-1)
   assign mag_a = op_a[W-1] ? (W'(0) - op_a) : op_a;
   assign mag_b = op_b[W-1] ? (W'(0) - op_b) : op_b;

   // one restoring remainder bit
   assign rem_sh   = {rem_ff, shift_ff[W-1]};
   assign rem_diff = rem_sh - {1'b0, smaller_ff};

   always_comb begin
      larger_in  = larger_ff;
      smaller_in = smaller_ff;
      rem_in     = rem_ff;
      shift_in   = shift_ff;
      count_in   = count_ff;
      zero_in    = zero_ff;
      if (cmd.load) begin
         larger_in  = mag_a;
         smaller_in = mag_b;
         zero_in    = (mag_a == '0) || (mag_b == '0);
      end
      if (cmd.div_init) begin
         rem_in   = '0;
         shift_in = larger_ff;
         count_in = CntW'(W - 1);
      end
      if (cmd.div_step) begin
         rem_in   = rem_diff[W] ? rem_sh[W-1:0] : rem_diff[W-1:0];
         shift_in = {shift_ff[W-2:0], 1'b0};
         count_in = count_ff - CntW'(1);
      end
      if (cmd.update) begin
         larger_in  = smaller_ff;
         smaller_in = rem_ff;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      larger_ff  <= larger_in;
      smaller_ff <= smaller_in;
      rem_ff     <= rem_in;
      shift_ff   <= shift_in;
      count_ff   <= count_in;
      zero_ff    <= zero_in;
   end

   assign status.zero_operand = zero_ff;
   assign status.smaller_zero = (smaller_ff == '0);
   assign status.count_last   = (count_ff == '0);
   assign result              = zero_ff ? '0 : larger_ff;

endmodule

// ===== design/sgcd_ctrl.sv =====
// controller of the signed gcd unit: sequences load, remainder passes and
// the hand-off to the result register
// depends on sgcd_pkg
module sgcd_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       out_free,
   output logic                       capture,
   input  sgcd_pkg::sgcd_status_type  status,
   output sgcd_pkg::sgcd_cmd_type     cmd
);
   import sgcd_pkg::*;

   sgcd_state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      capture   = 1'b0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            // zero operand or remainder reached zero
            if (status.zero_operand || status.smaller_zero) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_DIV_INIT;
            end
         end
         ST_DIV_INIT: begin
            cmd.div_init = 1'b1;
            state_in     = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.count_last) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_CHECK;
         end
         ST_FINISH: begin
            if (out_free) begin
               capture  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== design/signed_gcd_unit.sv =====
// Signed gcd unit: takes two signed operands per beat and returns the
// greatest common divisor of their magnitudes (the most negative value counts
// as 2^(OPERAND_WIDTH-1)), or 0 with zero_operand set when either operand is
// zero. One item is worked on at a time. Each Euclid remainder step runs on a
// bit-serial restoring unit (init, one bit per cycle, update, check); an
// item runs one such step per Euclid remainder, at most 45 at 32 bits (one
// of them spent when the second magnitude is the larger), between the
// accepted beat and the result capture; a zero operand goes from the check
// straight to the finish.
// A registered result stage lets the next item start while a result waits.
// Depends on sgcd_pkg, sgcd_ctrl and sgcd_dpath.
module signed_gcd_unit #(
   parameter int OPERAND_WIDTH = sgcd_pkg::OperandWidthDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  sgcd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output sgcd_pkg::rsp_type rsp_data
);
   import sgcd_pkg::*;

   localparam int W = OPERAND_WIDTH;

   sgcd_cmd_type    cmd;
   sgcd_status_type status;
   logic            capture;
   logic            out_free;
   logic [W-1:0]    op_a;
   logic [W-1:0]    op_b;
   logic [W-1:0]    result;
   logic [63:0]     a_ext;
   logic [63:0]     b_ext;
   logic [63:0]     res_ext;

   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_data_ff, rsp_data_in;

   // operands at the working width; bits above the field read as zero
   assign a_ext = {32'd0, req_data.value_a};
   assign b_ext = {32'd0, req_data.value_b};
   assign op_a  = a_ext[W-1:0];
   assign op_b  = b_ext[W-1:0];

   sgcd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .out_free  (out_free),
      .capture   (capture),
      .status    (status),
      .cmd       (cmd)
   );

   sgcd_dpath #(
      .OPERAND_WIDTH (W)
   ) u_dpath (
      .clock  (clock),
      .op_a   (op_a),
      .op_b   (op_b),
      .cmd    (cmd),
      .status (status),
      .result (result)
   );

   // result register
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign res_ext  = 64'(result);

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (capture) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.divisor      = res_ext[FieldWidth-1:0];
         rsp_data_in.zero_operand = status.zero_operand;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a beat taken on the input closes the input until the result is handed off
   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input open right after an accepted beat");

   // the result register is loaded only when it is empty or draining
   a_capture_free : assert property (@(posedge clock) disable iff (reset)
      capture |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result overwritten while waiting");

   // a zero operand always yields a zero divisor
   a_zero_result : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.zero_operand) |-> (rsp_data.divisor == '0))
      else $error("nonzero divisor with zero operand");

   // a valid gcd is never zero when it fits the field
   a_gcd_nonzero : assert property (@(posedge clock) disable iff (reset)
      (capture && !status.zero_operand) |=>
         ((W > FieldWidth) || (rsp_data.divisor != '0)))
      else $error("zero gcd without zero operand");

endmodule
